// ----- hw/rtl/dat_pkg.sv -----
`default_nettype none

package dat_pkg;

	localparam int ADDR_BITS = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;
	localparam int NODE_POS_W = 6;

	typedef logic [ADDR_BITS-1:0] addr_t;

	// Function codes of an input item.
	localparam logic [1:0] FUNC_TO_BUS = 2'd0;
	localparam logic [1:0] FUNC_TO_PHYS = 2'd1;
	localparam logic [1:0] FUNC_WRITE_WIN = 2'd2;

	// Translation modes.
	localparam logic [2:0] MODE_TABLE = 3'd0;
	localparam logic [2:0] MODE_FIXED_OFFSET = 3'd1;
	localparam logic [2:0] MODE_LOW_WINDOW = 3'd2;
	localparam logic [2:0] MODE_NODE_RELOC = 3'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELOC_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_OFFSET = 2'd2;

	localparam logic [2:0] MODE_RESET = MODE_LOW_WINDOW;

	localparam addr_t LOW_LIMIT = 48'h0000_1000_0000;
	localparam addr_t BRIDGE_OFFSET = 48'h0000_8000_0000;
	localparam addr_t HIGH_LIMIT = 48'h0000_9000_0000;
	localparam addr_t LOW_KEEP = 48'h0000_0fff_ffff;

	localparam logic [NODE_POS_W-1:0] NODE_SRC_BIT = 6'd44;
	localparam logic [NODE_POS_W-1:0] NODE_FIXED_BIT = 6'd37;
	localparam logic [NODE_POS_W-1:0] NODE_BASE_BIT = 6'd36;

	typedef struct packed {
		logic [1:0] func;
		addr_t address;
		logic [2:0] window_index;
		addr_t window_phys_start;
		addr_t window_bus_start;
		addr_t window_length;
	} in_item_t;

	typedef struct packed {
		addr_t out_address;
		logic miss;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic write_win;
		logic step;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic table_mode;
		logic hit;
		logic last;
		logic out_free;
	} ctrl_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dat_ctrl.sv -----
`default_nettype none

module dat_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_func,
	output logic in_ready,
	input dat_pkg::ctrl_status_t status,
	output dat_pkg::ctrl_cmd_t cmd
);
	import dat_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic accept;
	logic translate;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign translate = (in_func == FUNC_TO_BUS) || (in_func == FUNC_TO_PHYS);

	always_comb begin
		cmd.capture = accept && translate;
		cmd.write_win = accept && (in_func == FUNC_WRITE_WIN);
		cmd.step = (state_q == ST_SEARCH);
		cmd.load = (state_q == ST_FINISH) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && translate) begin
						state_q <= status.table_mode ? ST_SEARCH : ST_FINISH;
					end
				end
				ST_SEARCH: begin
					// Stop at the first hit or after the last window.
					if (status.hit || status.last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dat_datapath.sv -----
`default_nettype none

module dat_datapath #(
	parameter int NUM_WINDOWS = 8
) (
	input logic clk,
	input logic arst_n,
	input dat_pkg::in_item_t in_data,
	input dat_pkg::ctrl_cmd_t cmd,
	output dat_pkg::ctrl_status_t status,
	input logic cfg_we,
	input logic [dat_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dat_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output dat_pkg::out_item_t out_data
);
	import dat_pkg::*;

	localparam int IW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

	function automatic addr_t move_node(addr_t a, logic [NODE_POS_W-1:0] src,
			logic [NODE_POS_W-1:0] dst);
		logic [1:0] nid;
		nid = 2'(a >> src);
		return (a ^ (ADDR_BITS'(nid) << src)) | (ADDR_BITS'(nid) << dst);
	endfunction

	// Configuration registers.
	logic [2:0] mode_q;
	logic reloc_en_q;
	logic [1:0] node_offset_q;

	// Window table.
	addr_t phys_q [NUM_WINDOWS];
	addr_t bus_q [NUM_WINDOWS];
	addr_t size_q [NUM_WINDOWS];
	logic [NUM_WINDOWS-1:0] win_valid_q;

	// Item in flight.
	addr_t addr_q;
	logic to_bus_q;
	logic [IW-1:0] win_q;
	logic hit_q;
	addr_t diff_q;
	addr_t base_q;

	out_item_t out_q;
	logic out_valid_q;

	logic wr_ok;
	logic [IW-1:0] wr_idx;
	addr_t from_start;
	addr_t to_start;
	logic [ADDR_BITS:0] diff;
	logic hit;
	addr_t bridge;
	logic [NODE_POS_W-1:0] node_pos;
	out_item_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			reloc_en_q <= 1'b1;
			node_offset_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data;
				CFG_RELOC_EN: reloc_en_q <= cfg_data[0];
				CFG_NODE_OFFSET: node_offset_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign wr_ok = (32'(in_data.window_index) < NUM_WINDOWS);
	assign wr_idx = IW'(in_data.window_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= '0;
		end else if (cmd.write_win && wr_ok) begin
			win_valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_win && wr_ok) begin
			phys_q[wr_idx] <= in_data.window_phys_start;
			bus_q[wr_idx] <= in_data.window_bus_start;
			size_q[wr_idx] <= in_data.window_length;
		end
	end

	// One window is tested per cycle: a borrow-free difference below the size of a valid window is a hit.
	assign from_start = to_bus_q ? phys_q[win_q] : bus_q[win_q];
	assign to_start = to_bus_q ? bus_q[win_q] : phys_q[win_q];
	assign diff = {1'b0, addr_q} - {1'b0, from_start};
	assign hit = win_valid_q[win_q] && !diff[ADDR_BITS] && (diff[ADDR_BITS-1:0] < size_q[win_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.capture) begin
			win_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.step) begin
			if (hit) begin
				hit_q <= 1'b1;
			end else if (win_q != IW'(NUM_WINDOWS - 1)) begin
				win_q <= win_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= in_data.address;
			to_bus_q <= (in_data.func == FUNC_TO_BUS);
		end
		if (cmd.step && hit) begin
			diff_q <= diff[ADDR_BITS-1:0];
			base_q <= to_start;
		end
	end

	assign node_pos = NODE_BASE_BIT + NODE_POS_W'(node_offset_q);

	always_comb begin
		bridge = addr_q;
		case (mode_q)
			MODE_FIXED_OFFSET: begin
				if (addr_q >= LOW_LIMIT) begin
					bridge = to_bus_q ? addr_q - BRIDGE_OFFSET : addr_q + BRIDGE_OFFSET;
				end
			end
			MODE_LOW_WINDOW: begin
				if (to_bus_q) begin
					bridge = (addr_q < LOW_LIMIT) ? (addr_q | BRIDGE_OFFSET) : addr_q;
					if (reloc_en_q) begin
						bridge = move_node(bridge, NODE_SRC_BIT, NODE_FIXED_BIT);
					end
				end else begin
					if (addr_q >= BRIDGE_OFFSET && addr_q < HIGH_LIMIT) begin
						bridge = addr_q & LOW_KEEP;
					end
					if (reloc_en_q) begin
						bridge = move_node(bridge, NODE_FIXED_BIT, NODE_SRC_BIT);
					end
				end
			end
			MODE_NODE_RELOC: begin
				if (reloc_en_q) begin
					bridge = to_bus_q ? move_node(addr_q, NODE_SRC_BIT, node_pos)
						: move_node(addr_q, node_pos, NODE_SRC_BIT);
				end
			end
			default: bridge = addr_q;
		endcase
	end

	always_comb begin
		if (mode_q == MODE_TABLE) begin
			result.out_address = hit_q ? base_q + diff_q : '0;
			result.miss = !hit_q;
		end else begin
			result.out_address = bridge;
			result.miss = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		status.table_mode = (mode_q == MODE_TABLE);
		status.hit = hit;
		status.last = (win_q == IW'(NUM_WINDOWS - 1));
		status.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dma_address_translator_top.sv -----
`default_nettype none
// A bridge or identity result is registered into the output once the output is free; in
// window table mode the search first tests 1 to NUM_WINDOWS windows, up to the first hit.
// One item at a time; the table search tests one window per cycle, and a busy output holds
// the finish state. A window write is taken while idle and leaves the block idle.
// Reset clears all windows, sets mode 2 with node relocation enabled and offset zero.

module dma_address_translator_top #(
	parameter int NUM_WINDOWS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dat_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dat_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [dat_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dat_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dat_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_status_t status;

	dat_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_func(in_data.func),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	dat_datapath #(
		.NUM_WINDOWS(NUM_WINDOWS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cmd(cmd),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire
